// ===== src/tbk_pkg.sv =====
// ----------------------------------------------------------------------------
// Timer bank package
// Opcodes, defaults and the word that travels down the cell chain.
// ----------------------------------------------------------------------------
package tbk_pkg;

	localparam int PERIODIC_SLOTS_DEF = 8;
	localparam int ONESHOT_SLOTS_DEF  = 8;
	localparam int MASK_W             = 8;

	localparam logic [2:0] OP_TICK        = 3'd0;
	localparam logic [2:0] OP_ADD_PER     = 3'd1;
	localparam logic [2:0] OP_ADD_ONE     = 3'd2;
	localparam logic [2:0] OP_CANCEL_PER  = 3'd3;
	localparam logic [2:0] OP_CANCEL_ONE  = 3'd4;
	localparam logic [2:0] OP_START_DELAY = 3'd5;

	typedef struct packed {
		logic              valid;
		logic [2:0]        op;
		logic [15:0]       period;
		logic [3:0]        handle;
		logic              taken;
		logic [3:0]        grant;
		logic [MASK_W-1:0] fired_per;
		logic [MASK_W-1:0] fired_one;
	} tbk_token_t;

endpackage

// ===== src/tbk_cell.sv =====
// ----------------------------------------------------------------------------
// Timer bank cell
// Holds periodic slot IDX and oneshot slot IDX; applies the passing word
// and registers it before handing it to the next cell.
// ----------------------------------------------------------------------------
module tbk_cell #(
	parameter int   IDX     = 0,
	parameter logic HAS_PER = 1'b1,
	parameter logic HAS_ONE = 1'b1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tbk_pkg::tbk_token_t tok_in,
	output tbk_pkg::tbk_token_t tok_out
);
	import tbk_pkg::*;

	localparam logic [3:0]        GRANT    = 4'(IDX + 1);
	localparam logic [4:0]        HANDLE   = 5'(IDX + 1);
	localparam logic [MASK_W-1:0] MASK_BIT = (IDX < MASK_W) ? MASK_W'(1 << IDX) : '0;

	logic        per_use_q, one_use_q;
	logic [15:0] per_reload_q, per_rem_q, one_rem_q;

	logic        per_use_d, one_use_d;
	logic [15:0] per_reload_d, per_rem_d, one_rem_d;
	logic [15:0] per_dec, one_dec;
	tbk_token_t  tok_d, tok_q;

	assign per_dec = per_rem_q - 16'd1;
	assign one_dec = one_rem_q - 16'd1;

	always_comb begin
		tok_d        = tok_in;
		per_use_d    = per_use_q;
		one_use_d    = one_use_q;
		per_reload_d = per_reload_q;
		per_rem_d    = per_rem_q;
		one_rem_d    = one_rem_q;
		if (tok_in.valid) begin
			case (tok_in.op)
				OP_TICK: begin
					if (per_use_q) begin
						if (per_dec == 16'd0) begin
							per_rem_d       = per_reload_q;
							tok_d.fired_per = tok_in.fired_per | MASK_BIT;
						end else begin
							per_rem_d = per_dec;
						end
					end
					if (one_use_q) begin
						one_rem_d = one_dec;
						if (one_dec == 16'd0) begin
							one_use_d       = 1'b0;
							tok_d.fired_one = tok_in.fired_one | MASK_BIT;
						end
					end
				end
				OP_ADD_PER: begin
					// first free slot down the chain claims the word
					if (HAS_PER && !tok_in.taken && !per_use_q) begin
						per_use_d    = 1'b1;
						per_reload_d = tok_in.period;
						per_rem_d    = tok_in.period;
						tok_d.taken  = 1'b1;
						tok_d.grant  = GRANT;
					end
				end
				OP_ADD_ONE: begin
					if (HAS_ONE && !tok_in.taken && !one_use_q) begin
						one_use_d   = 1'b1;
						one_rem_d   = tok_in.period;
						tok_d.taken = 1'b1;
						tok_d.grant = GRANT;
					end
				end
				OP_CANCEL_PER: begin
					if ({1'b0, tok_in.handle} == HANDLE) per_use_d = 1'b0;
				end
				OP_CANCEL_ONE: begin
					if ({1'b0, tok_in.handle} == HANDLE) one_use_d = 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			per_use_q <= 1'b0;
			one_use_q <= 1'b0;
			tok_q     <= '0;
		end else begin
			per_use_q <= per_use_d;
			one_use_q <= one_use_d;
			tok_q     <= tok_d;
		end
	end

	always_ff @(posedge clk) begin
		per_reload_q <= per_reload_d;
		per_rem_q    <= per_rem_d;
		one_rem_q    <= one_rem_d;
	end

	assign tok_out = tok_q;

endmodule

// ===== src/periodic_and_oneshot_timer_bank_core.sv =====
// ----------------------------------------------------------------------------
// Periodic and oneshot timer bank
// Tick counter, delay counter and a chain of timer slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   Command port: a word is taken at a clock edge with start high and busy
//   low. opcode selects tick, add periodic/oneshot, cancel periodic/oneshot
//   or start delay; period_ticks, slot_handle and delay_ticks are the
//   operands.
//   The word walks the slot chain one cell per cycle; done is registered
//   from the word leaving the last cell, and busy drops while the word is
//   in the last cell, so a new command can be taken as the previous one
//   leaves the chain.
//   Result fields (fired masks, new_handle, tick_count, delay_active) are
//   registered with done, valid in the done cycle and held until the next
//   result; the receiver cannot stall and must take the word then.
//   Reset clears the tick and delay counters and frees every slot; no
//   clearing pass is needed.
// ----------------------------------------------------------------------------
module periodic_and_oneshot_timer_bank_core #(
	parameter int PERIODIC_SLOTS = tbk_pkg::PERIODIC_SLOTS_DEF,
	parameter int ONESHOT_SLOTS  = tbk_pkg::ONESHOT_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  opcode,
	input  logic [15:0] period_ticks,
	input  logic [3:0]  slot_handle,
	input  logic [31:0] delay_ticks,
	output logic        done,
	output logic [7:0]  fired_periodic,
	output logic [7:0]  fired_oneshot,
	output logic [3:0]  new_handle,
	output logic [31:0] tick_count,
	output logic        delay_active
);
	import tbk_pkg::*;

	localparam int N = (PERIODIC_SLOTS > ONESHOT_SLOTS) ? PERIODIC_SLOTS : ONESHOT_SLOTS;

	tbk_token_t  tok [N+1];
	logic [N-1:0] valid_vec;
	logic        accept;
	logic        busy_q, done_q, delay_act_q;
	logic [31:0] tick_q, delay_q, tick_res_q;
	logic [7:0]  fired_per_q, fired_one_q;
	logic [3:0]  grant_q;
	tbk_token_t  last;

	assign accept = start && !busy;
	assign last   = tok[N];

	always_comb begin
		tok[0]           = '0;
		tok[0].valid     = accept;
		tok[0].op        = opcode;
		tok[0].period    = period_ticks;
		tok[0].handle    = slot_handle;
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		tbk_cell #(
			.IDX     (i),
			.HAS_PER (i < PERIODIC_SLOTS),
			.HAS_ONE (i < ONESHOT_SLOTS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1])
		);
		assign valid_vec[i] = tok[i+1].valid;
	end

	// free for the next word in the cycle the current one leaves the chain
	assign busy = busy_q && !last.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			tick_q  <= '0;
			delay_q <= '0;
		end else begin
			done_q <= last.valid;
			if (accept) busy_q <= 1'b1;
			else if (last.valid) busy_q <= 1'b0;
			if (accept) begin
				case (opcode)
					OP_TICK: begin
						tick_q <= tick_q + 32'd1;
						if (delay_q != 32'd0) delay_q <= delay_q - 32'd1;
					end
					OP_START_DELAY: delay_q <= delay_ticks;
					default: begin
					end
				endcase
			end
		end
	end

	// snapshot the counters as the word leaves; the next word may start now
	always_ff @(posedge clk) begin
		if (last.valid) begin
			fired_per_q <= last.fired_per;
			fired_one_q <= last.fired_one;
			grant_q     <= last.taken ? last.grant : 4'd0;
			delay_act_q <= (delay_q != 32'd0);
			tick_res_q  <= tick_q;
		end
	end

	assign done           = done_q;
	assign fired_periodic = fired_per_q;
	assign fired_oneshot  = fired_one_q;
	assign new_handle     = grant_q;
	assign tick_count     = tick_res_q;
	assign delay_active   = delay_act_q;

`ifndef SYNTHESIS
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(valid_vec)) else $error("more than one word in the chain");

	a_busy_tracks_chain: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q == (valid_vec != '0)) else $error("busy out of step with chain");

	a_fired_only_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		last.valid && last.op != OP_TICK |-> last.fired_per == '0 && last.fired_one == '0)
		else $error("fired mask on a non-tick word");

	a_tick_advances: assert property (@(posedge clk) disable iff (!arst_n)
		accept && opcode == OP_TICK |=> tick_q == $past(tick_q) + 32'd1)
		else $error("tick counter did not advance");
`endif

endmodule
